FILE: hdl/jlt_pkg.sv
// ============================================================================
// jlt_pkg
// Shared types, character codes and helpers of the JSON-like tokenizer.
// ============================================================================
package jlt_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int LEN_BITS_DEF = 16;
    localparam int QDEPTH       = 4;
    localparam int QPTR_BITS    = $clog2(QDEPTH);

    localparam logic [7:0] CH_END     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [63:0] POS_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ACC_THRESH = 64'd922337203685477580;
    localparam logic [3:0]  POS_LAST_D = 4'd7;
    localparam logic [3:0]  NEG_LAST_D = 4'd8;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_BOOL  = 3'd1,
        MODE_STR   = 3'd2,
        MODE_MINUS = 3'd3,
        MODE_INT   = 3'd4,
        MODE_FRAC  = 3'd5,
        MODE_IDENT = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        KIND_END     = 4'd0,
        KIND_LBRACE  = 4'd1,
        KIND_RBRACE  = 4'd2,
        KIND_LBRACK  = 4'd3,
        KIND_RBRACK  = 4'd4,
        KIND_COMMA   = 4'd5,
        KIND_COLON   = 4'd6,
        KIND_TRUE    = 4'd7,
        KIND_FALSE   = 4'd8,
        KIND_STRING  = 4'd9,
        KIND_INT     = 4'd10,
        KIND_DECIMAL = 4'd11,
        KIND_IDENT   = 4'd12
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BOOL_END   = 3'd1,
        ST_BOOL_BAD   = 3'd2,
        ST_STR_END    = 3'd3,
        ST_LONE_MINUS = 3'd4
    } status_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  status;
        logic [31:0] start_offset;
        logic [31:0] start_line;
        logic [15:0] start_col;
        logic [15:0] length;
        logic [63:0] value;
        logic [7:0]  frac_digits;
        logic        last;
    } tok_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // magnitude * 10 + d, clamped at the signed limit
    function automatic logic [63:0] acc_digit(input logic [63:0] acc, input logic neg,
                                              input logic [3:0] d);
        logic        over;
        logic [63:0] lim;
        lim  = neg ? NEG_LIMIT : POS_LIMIT;
        over = (acc > ACC_THRESH) ||
               ((acc == ACC_THRESH) && (d > (neg ? NEG_LAST_D : POS_LAST_D)));
        return over ? lim : ((acc << 3) + (acc << 1) + {60'd0, d});
    endfunction

endpackage

FILE: hdl/jlt_char_if.sv
// ============================================================================
// jlt_char_if
// Character channel: one byte per transaction, zero marks end of input.
// ============================================================================
interface jlt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

FILE: hdl/jlt_token_if.sv
// ============================================================================
// jlt_token_if
// Token channel: one token with its position and value per transaction.
// ============================================================================
interface jlt_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [2:0]  status;
    logic [31:0] start_offset;
    logic [31:0] start_line;
    logic [15:0] start_col;
    logic [15:0] length;
    logic signed [63:0] value;
    logic [7:0]  frac_digits;
    logic        last;

    modport source (output valid, output kind, output status, output start_offset,
                    output start_line, output start_col, output length, output value,
                    output frac_digits, output last, input ready);
    modport sink   (input valid, input kind, input status, input start_offset,
                    input start_line, input start_col, input length, input value,
                    input frac_digits, input last, output ready);
endinterface

FILE: hdl/json_like_tokenizer_top.sv
// ============================================================================
// json_like_tokenizer_top
// Streaming tokenizer for JSON-like text, one character per cycle unless stalled.
//
//   channel  | modport | payload                                   | role
//   ---------+---------+-------------------------------------------+-----------
//   chars    | sink    | ch                                        | text in
//   tokens   | source  | kind status start_* length value frac last | tokens out
//
// A character is taken in every cycle with queue room; its state update is one pass of
// logic into the state registers and a four-entry token queue.
// A character gives zero, one or two tokens; the queue drains one per cycle while
// the sink is ready, so input stalls only while fewer than two queue entries are free.
// Reset: mode idle, position and column 0, line 1, queue empty.
// ============================================================================
module json_like_tokenizer_top
    import jlt_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    jlt_char_if.sink      chars,
    jlt_token_if.source   tokens
);

    localparam int LEN_W = (LEN_BITS >= 16) ? 16 : LEN_BITS;

    mode_t                mode_reg,      mode_next;
    logic [POS_BITS-1:0]  position_reg,  position_next;
    logic [POS_BITS-1:0]  line_reg,      line_next;
    logic [15:0]          column_reg,    column_next;
    logic [POS_BITS-1:0]  tok_start_reg, tok_start_next;
    logic [POS_BITS-1:0]  tok_line_reg,  tok_line_next;
    logic [15:0]          tok_col_reg,   tok_col_next;
    logic [LEN_W-1:0]     tok_len_reg,   tok_len_next;
    logic [63:0]          acc_reg,       acc_next;
    logic                 neg_reg,       neg_next;
    logic [7:0]           frac_reg,      frac_next;

    tok_t                 fifo_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    logic                 accept;
    logic                 pop;
    logic [7:0]           ch;
    logic                 ch_ws;
    logic                 ch_digit;
    logic [63:0]          acc_step;
    logic [LEN_W-1:0]     len_sat;
    logic [63:0]          signed_val;
    logic                 done;
    logic                 have_a, have_b;
    tok_t                 res_a, res_b;
    tok_t                 slot0, slot1;
    logic [1:0]           nres;

    assign ch         = chars.ch;
    assign accept     = chars.valid && chars.ready;
    assign pop        = tokens.valid && tokens.ready;
    assign chars.ready = (count_reg <= (QPTR_BITS+1)'(QDEPTH - 2));
    assign ch_ws      = is_ws(ch);
    assign ch_digit   = is_digit(ch);
    assign acc_step   = acc_digit(acc_reg, neg_reg, ch[3:0]);
    assign len_sat    = (tok_len_reg == '1) ? tok_len_reg : tok_len_reg + 1'b1;
    assign signed_val = neg_reg ? (64'd0 - acc_reg) : acc_reg;

    always_comb
    begin
        mode_next      = mode_reg;
        tok_start_next = tok_start_reg;
        tok_line_next  = tok_line_reg;
        tok_col_next   = tok_col_reg;
        tok_len_next   = tok_len_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        frac_next      = frac_reg;
        done           = 1'b1;
        have_a         = 1'b0;
        have_b         = 1'b0;

        res_a              = '0;
        res_a.start_offset = 32'(tok_start_reg);
        res_a.start_line   = 32'(tok_line_reg);
        res_a.start_col    = tok_col_reg;
        res_a.length       = 16'(tok_len_reg);

        res_b              = '0;
        res_b.start_offset = 32'(position_reg);
        res_b.start_line   = 32'(line_reg);
        res_b.start_col    = column_reg;
        res_b.length       = 16'd1;

        unique case (mode_reg)
            MODE_BOOL:
            begin
                have_a       = 1'b1;
                res_a.length = 16'd2;
                mode_next    = MODE_IDLE;
                if (ch == CH_END)
                begin
                    res_a.kind   = KIND_TRUE;
                    res_a.status = ST_BOOL_END;
                    res_a.length = 16'd1;
                    done         = 1'b0;
                end
                else if (ch == CH_T)
                begin
                    res_a.kind = KIND_TRUE;
                end
                else if (ch == CH_F)
                begin
                    res_a.kind = KIND_FALSE;
                end
                else
                begin
                    res_a.kind   = KIND_TRUE;
                    res_a.status = ST_BOOL_BAD;
                end
            end
            MODE_STR:
            begin
                res_a.kind = KIND_STRING;
                if (ch == CH_QUOTE)
                begin
                    have_a    = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else if (ch == CH_END)
                begin
                    have_a       = 1'b1;
                    res_a.status = ST_STR_END;
                    done         = 1'b0;
                end
                else
                begin
                    tok_len_next = len_sat;
                end
            end
            MODE_MINUS:
            begin
                if (ch_digit)
                begin
                    acc_next     = acc_step;
                    tok_len_next = len_sat;
                    mode_next    = MODE_INT;
                end
                else
                begin
                    have_a       = 1'b1;
                    res_a.kind   = KIND_INT;
                    res_a.status = ST_LONE_MINUS;
                    res_a.length = 16'd1;
                    done         = 1'b0;
                end
            end
            MODE_INT:
            begin
                if (ch_digit)
                begin
                    acc_next     = acc_step;
                    tok_len_next = len_sat;
                end
                else if (ch == CH_DOT)
                begin
                    tok_len_next = len_sat;
                    mode_next    = MODE_FRAC;
                end
                else
                begin
                    have_a      = 1'b1;
                    res_a.kind  = KIND_INT;
                    res_a.value = signed_val;
                    done        = 1'b0;
                end
            end
            MODE_FRAC:
            begin
                if (ch_digit)
                begin
                    acc_next     = acc_step;
                    tok_len_next = len_sat;
                    frac_next    = (frac_reg == 8'hFF) ? frac_reg : frac_reg + 8'd1;
                end
                else
                begin
                    have_a            = 1'b1;
                    res_a.kind        = KIND_DECIMAL;
                    res_a.value       = signed_val;
                    res_a.frac_digits = frac_reg;
                    done              = 1'b0;
                end
            end
            MODE_IDENT:
            begin
                if ((ch == CH_COLON) || (ch == CH_END) || ch_ws)
                begin
                    have_a     = 1'b1;
                    res_a.kind = KIND_IDENT;
                    done       = 1'b0;
                end
                else
                begin
                    tok_len_next = len_sat;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        if (!done)
        begin
            mode_next = MODE_IDLE;
            if (!ch_ws)
            begin
                tok_start_next = position_reg;
                tok_line_next  = line_reg;
                tok_col_next   = column_reg;
                tok_len_next   = LEN_W'(1);
                acc_next       = '0;
                neg_next       = 1'b0;
                frac_next      = '0;
                unique case (ch)
                    CH_END:
                    begin
                        tok_len_next = '0;
                        have_b       = 1'b1;
                        res_b.kind   = KIND_END;
                        res_b.length = 16'd0;
                    end
                    CH_LBRACE:
                    begin
                        have_b     = 1'b1;
                        res_b.kind = KIND_LBRACE;
                    end
                    CH_RBRACE:
                    begin
                        have_b     = 1'b1;
                        res_b.kind = KIND_RBRACE;
                    end
                    CH_LBRACK:
                    begin
                        have_b     = 1'b1;
                        res_b.kind = KIND_LBRACK;
                    end
                    CH_RBRACK:
                    begin
                        have_b     = 1'b1;
                        res_b.kind = KIND_RBRACK;
                    end
                    CH_COMMA:
                    begin
                        have_b     = 1'b1;
                        res_b.kind = KIND_COMMA;
                    end
                    CH_COLON:
                    begin
                        have_b     = 1'b1;
                        res_b.kind = KIND_COLON;
                    end
                    CH_HASH:
                    begin
                        mode_next = MODE_BOOL;
                    end
                    CH_QUOTE:
                    begin
                        tok_len_next = '0;
                        mode_next    = MODE_STR;
                    end
                    CH_MINUS:
                    begin
                        neg_next  = 1'b1;
                        mode_next = MODE_MINUS;
                    end
                    default:
                    begin
                        if (ch_digit)
                        begin
                            acc_next  = {60'd0, ch[3:0]};
                            mode_next = MODE_INT;
                        end
                        else
                        begin
                            mode_next = MODE_IDENT;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        nres       = {1'b0, have_a} + {1'b0, have_b};
        slot0      = have_a ? res_a : res_b;
        slot0.last = (nres == 2'd1);
        slot1      = res_b;
        slot1.last = 1'b1;
    end

    always_comb
    begin
        position_next = position_reg + 1'b1;
        line_next     = line_reg;
        column_next   = column_reg;
        if (ch == CH_LF)
        begin
            line_next   = line_reg + 1'b1;
            column_next = '0;
        end
        else if (column_reg != 16'hFFFF)
        begin
            column_next = column_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            position_reg  <= '0;
            line_reg      <= POS_BITS'(1);
            column_reg    <= '0;
            tok_start_reg <= '0;
            tok_line_reg  <= POS_BITS'(1);
            tok_col_reg   <= '0;
            tok_len_reg   <= '0;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            frac_reg      <= '0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            position_reg  <= position_next;
            line_reg      <= line_next;
            column_reg    <= column_next;
            tok_start_reg <= tok_start_next;
            tok_line_reg  <= tok_line_next;
            tok_col_reg   <= tok_col_next;
            tok_len_reg   <= tok_len_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            frac_reg      <= frac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (nres != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= slot0;
        end
        if (accept && (nres == 2'd2))
        begin
            fifo_reg[wr_ptr_reg + 1'b1] <= slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(nres);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (accept ? (QPTR_BITS+1)'(nres) : '0)
                                   - (QPTR_BITS+1)'(pop);
        end
    end

    assign tokens.valid        = (count_reg != '0);
    assign tokens.kind         = fifo_reg[rd_ptr_reg].kind;
    assign tokens.status       = fifo_reg[rd_ptr_reg].status;
    assign tokens.start_offset = fifo_reg[rd_ptr_reg].start_offset;
    assign tokens.start_line   = fifo_reg[rd_ptr_reg].start_line;
    assign tokens.start_col    = fifo_reg[rd_ptr_reg].start_col;
    assign tokens.length       = fifo_reg[rd_ptr_reg].length;
    assign tokens.value        = fifo_reg[rd_ptr_reg].value;
    assign tokens.frac_digits  = fifo_reg[rd_ptr_reg].frac_digits;
    assign tokens.last         = fifo_reg[rd_ptr_reg].last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_BITS+1)'(QDEPTH))
        else $error("token queue overflow");

    a_end_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (ch == CH_END)) |-> have_b && (res_b.kind == KIND_END))
        else $error("end of input without end token");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (ch == CH_END)) |=> (mode_reg == MODE_IDLE))
        else $error("tokenizer not idle after end of input");

    a_queue_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (nres == 2'd2) && !pop) |=> (count_reg == $past(count_reg) + 2'd2))
        else $error("two-token transaction not queued");

endmodule
